// ----- hdl/ctb_pkg.sv -----
// ============================================================================
// ctb_pkg
// Shared types and constants for the countdown timer bank: the stored timer
// entry, the memory access bundle, command codes and the sequencer states.
// ============================================================================
package ctb_pkg;

   localparam int BANK_DEPTH     = 16;
   localparam int IDX_W          = 4;
   localparam int CNT_W          = 32;
   localparam int MASK_W         = 16;
   localparam int TIMER_IDX_W    = 8;
   localparam int FUNC_W         = 3;
   localparam int NUM_TIMERS_DEF = 16;

   localparam logic signed [CNT_W-1:0] CNT_IDLE = -32'sd1;
   localparam logic signed [CNT_W-1:0] CNT_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [CNT_W-1:0] CNT_MIN  = 32'sh8000_0000;

   typedef enum logic [FUNC_W-1:0] {
      FN_TICK    = 3'd0,
      FN_START   = 3'd1,
      FN_RESTART = 3'd2,
      FN_STOP    = 3'd3,
      FN_ADD     = 3'd4,
      FN_QUERY   = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_CMD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                    active;
      logic signed [CNT_W-1:0] count;
   } entry_type;

   localparam entry_type ENTRY_IDLE = '{active: 1'b0, count: CNT_IDLE};

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
   } mem_req_type;

endpackage

// ----- hdl/countdown_timer_bank_top.sv -----
// Sequencing: a tick request reads entry 0 and then sweeps the timer memory in
// ST_SWEEP (one entry read and one written per cycle) before ST_RESP; any other
// request passes through ST_CMD to ST_RESP. One request is in progress at a time,
// and ST_RESP holds the new response while a previous response is stalled.
// Reset clears the sequencer and the memory's valid bits, so every timer reads
// as idle with count -1 straight away; no clearing pass is needed.
// ============================================================================
// countdown_timer_bank_top
// A bank of countdown timers with start, restart, stop, add, query and tick
// requests; timer state is held in a single-port-per-direction memory.
// ============================================================================
module countdown_timer_bank_top #(
   parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ctb_pkg::FUNC_W-1:0]             req_func,
   input  logic [ctb_pkg::TIMER_IDX_W-1:0]        req_timer_index,
   input  logic signed [ctb_pkg::CNT_W-1:0]       req_amount,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic                                   rsp_active,
   output logic signed [ctb_pkg::CNT_W-1:0]       rsp_remaining,
   output logic [ctb_pkg::MASK_W-1:0]             rsp_expired_mask
);

   ctb_pkg::mem_req_type mem_req;
   ctb_pkg::entry_type   mem_rd_data;

   ctb_ctrl #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_timer_index  (req_timer_index),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_active       (rsp_active),
      .rsp_remaining    (rsp_remaining),
      .rsp_expired_mask (rsp_expired_mask),
      .mem_req          (mem_req),
      .mem_rd_data      (mem_rd_data)
   );

   ctb_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

endmodule

// ----- hdl/ctb_store.sv -----
// ============================================================================
// ctb_store
// Timer state memory: one entry per timer, one read and one write port, read
// data registered. Per-entry valid bits make unwritten entries read as idle.
// ============================================================================
module ctb_store (
   input  logic                 clock,
   input  logic                 reset,
   input  ctb_pkg::mem_req_type mem_req,
   output ctb_pkg::entry_type   rd_data
);

   ctb_pkg::entry_type                     mem [ctb_pkg::BANK_DEPTH];
   logic [ctb_pkg::BANK_DEPTH-1:0]         vld_ff;
   ctb_pkg::entry_type                     rd_data_ff;
   logic                                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            vld_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_vld_ff <= vld_ff[mem_req.rd_addr];
         end
      end
   end

   // An entry never written since reset holds the idle value.
   assign rd_data = rd_vld_ff ? rd_data_ff : ctb_pkg::ENTRY_IDLE;

endmodule

// ----- hdl/ctb_ctrl.sv -----
// ============================================================================
// ctb_ctrl
// Command sequencer: reads the addressed entry, applies the command and
// writes it back if the command changes it; a tick sweeps every timer with a pipelined read/write.
// ============================================================================
module ctb_ctrl #(
   parameter int NUM_TIMERS = ctb_pkg::NUM_TIMERS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ctb_pkg::FUNC_W-1:0]             req_func,
   input  logic [ctb_pkg::TIMER_IDX_W-1:0]        req_timer_index,
   input  logic signed [ctb_pkg::CNT_W-1:0]       req_amount,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic                                   rsp_active,
   output logic signed [ctb_pkg::CNT_W-1:0]       rsp_remaining,
   output logic [ctb_pkg::MASK_W-1:0]             rsp_expired_mask,
   output ctb_pkg::mem_req_type                   mem_req,
   input  ctb_pkg::entry_type                     mem_rd_data
);

   localparam logic [ctb_pkg::IDX_W-1:0]       LAST_IDX  = ctb_pkg::IDX_W'(NUM_TIMERS - 1);
   localparam logic [ctb_pkg::TIMER_IDX_W-1:0] NUM_LIMIT = ctb_pkg::TIMER_IDX_W'(NUM_TIMERS);

   ctb_pkg::state_type                    state_ff, state_in;
   logic [ctb_pkg::FUNC_W-1:0]            func_ff, func_in;
   logic [ctb_pkg::TIMER_IDX_W-1:0]       idx_ff, idx_in;
   logic signed [ctb_pkg::CNT_W-1:0]      amount_ff, amount_in;
   logic [ctb_pkg::IDX_W-1:0]             cnt_ff, cnt_in;
   logic [ctb_pkg::MASK_W-1:0]            mask_ff, mask_in;
   logic                                  res_acc_ff, res_acc_in;
   logic                                  res_act_ff, res_act_in;
   logic signed [ctb_pkg::CNT_W-1:0]      res_rem_ff, res_rem_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic                                  rsp_acc_ff, rsp_acc_in;
   logic                                  rsp_act_ff, rsp_act_in;
   logic signed [ctb_pkg::CNT_W-1:0]      rsp_rem_ff, rsp_rem_in;
   logic [ctb_pkg::MASK_W-1:0]            rsp_mask_ff, rsp_mask_in;

   logic                                  idx_ok;
   ctb_pkg::entry_type                    cur;
   ctb_pkg::entry_type                    tick_e;
   ctb_pkg::entry_type                    cmd_e;
   logic                                  tick_exp;
   logic                                  cmd_acc;
   logic                                  cmd_wr;
   logic signed [ctb_pkg::CNT_W:0]        sum;
   logic signed [ctb_pkg::CNT_W-1:0]      sat_sum;

   assign idx_ok = (idx_ff < NUM_LIMIT);
   assign cur    = mem_rd_data;

   // Tick update of one entry: decrement a positive count, then expire at zero.
   always_comb begin
      tick_e   = cur;
      tick_exp = 1'b0;
      if (cur.active && !cur.count[ctb_pkg::CNT_W-1] && (cur.count != '0)) begin
         tick_e.count = cur.count - ctb_pkg::CNT_W'(1);
      end
      if (tick_e.active && (tick_e.count == '0)) begin
         tick_e   = ctb_pkg::ENTRY_IDLE;
         tick_exp = 1'b1;
      end
   end

   // Add saturates at the signed 32-bit limits.
   always_comb begin
      sum = {cur.count[ctb_pkg::CNT_W-1], cur.count}
          + {amount_ff[ctb_pkg::CNT_W-1], amount_ff};
      if (sum[ctb_pkg::CNT_W] != sum[ctb_pkg::CNT_W-1]) begin
         sat_sum = sum[ctb_pkg::CNT_W] ? ctb_pkg::CNT_MIN : ctb_pkg::CNT_MAX;
      end else begin
         sat_sum = sum[ctb_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      cmd_e   = cur;
      cmd_acc = 1'b0;
      cmd_wr  = 1'b0;
      case (ctb_pkg::func_type'(func_ff))
         ctb_pkg::FN_START: begin
            if (idx_ok && !cur.active) begin
               cmd_e   = '{active: 1'b1, count: amount_ff};
               cmd_acc = 1'b1;
               cmd_wr  = 1'b1;
            end
         end
         ctb_pkg::FN_RESTART: begin
            if (idx_ok && cur.active) begin
               cmd_e.count = amount_ff;
               cmd_acc     = 1'b1;
               cmd_wr      = 1'b1;
            end
         end
         ctb_pkg::FN_STOP: begin
            if (idx_ok && cur.active) begin
               cmd_e   = ctb_pkg::ENTRY_IDLE;
               cmd_acc = 1'b1;
               cmd_wr  = 1'b1;
            end
         end
         ctb_pkg::FN_ADD: begin
            if (idx_ok && cur.active) begin
               cmd_e.count = sat_sum;
               cmd_acc     = 1'b1;
               cmd_wr      = 1'b1;
            end
         end
         ctb_pkg::FN_QUERY: begin
            cmd_acc = idx_ok && cur.active;
         end
         default: begin
            cmd_acc = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctb_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      idx_ff      <= idx_in;
      amount_ff   <= amount_in;
      cnt_ff      <= cnt_in;
      mask_ff     <= mask_in;
      res_acc_ff  <= res_acc_in;
      res_act_ff  <= res_act_in;
      res_rem_ff  <= res_rem_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_rem_ff  <= rsp_rem_in;
      rsp_mask_ff <= rsp_mask_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      amount_in    = amount_ff;
      cnt_in       = cnt_ff;
      mask_in      = mask_ff;
      res_acc_in   = res_acc_ff;
      res_act_in   = res_act_ff;
      res_rem_in   = res_rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_rem_in   = rsp_rem_ff;
      rsp_mask_in  = rsp_mask_ff;
      mem_req      = '0;
      req_stall    = (state_ff != ctb_pkg::ST_IDLE);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ctb_pkg::ST_IDLE: begin
            if (req_valid) begin
               func_in    = req_func;
               idx_in     = req_timer_index;
               amount_in  = req_amount;
               cnt_in     = '0;
               mask_in    = '0;
               res_acc_in = 1'b1;
               res_act_in = 1'b0;
               res_rem_in = ctb_pkg::CNT_IDLE;
               mem_req.rd_en = 1'b1;
               if (req_func == ctb_pkg::FN_TICK) begin
                  mem_req.rd_addr = '0;
                  state_in        = ctb_pkg::ST_SWEEP;
               end else begin
                  mem_req.rd_addr = req_timer_index[ctb_pkg::IDX_W-1:0];
                  state_in        = ctb_pkg::ST_CMD;
               end
            end
         end
         ctb_pkg::ST_SWEEP: begin
            // Entry cnt_ff is written back while entry cnt_ff + 1 is read.
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff;
            mem_req.wr_data = tick_e;
            if (tick_exp) begin
               mask_in[cnt_ff] = 1'b1;
            end
            if (idx_ok && (idx_ff[ctb_pkg::IDX_W-1:0] == cnt_ff)) begin
               res_act_in = tick_e.active;
               res_rem_in = tick_e.active ? tick_e.count : ctb_pkg::CNT_IDLE;
            end
            if (cnt_ff == LAST_IDX) begin
               state_in = ctb_pkg::ST_RESP;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cnt_ff + ctb_pkg::IDX_W'(1);
               cnt_in          = cnt_ff + ctb_pkg::IDX_W'(1);
            end
         end
         ctb_pkg::ST_CMD: begin
            mem_req.wr_en   = cmd_wr;
            mem_req.wr_addr = idx_ff[ctb_pkg::IDX_W-1:0];
            mem_req.wr_data = cmd_e;
            res_acc_in      = cmd_acc;
            res_act_in      = idx_ok && cmd_e.active;
            res_rem_in      = (idx_ok && cmd_e.active) ? cmd_e.count : ctb_pkg::CNT_IDLE;
            state_in        = ctb_pkg::ST_RESP;
         end
         ctb_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_act_in   = res_act_ff;
               rsp_rem_in   = res_rem_ff;
               rsp_mask_in  = mask_ff;
               state_in     = ctb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctb_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_active       = rsp_act_ff;
   assign rsp_remaining    = rsp_rem_ff;
   assign rsp_expired_mask = rsp_mask_ff;

endmodule
